// ===== rtl/great_circle_distance_defines.svh =====
// assertion macros for the great circle distance block
// included by files that carry concurrent assertions, no other dependencies
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gcd_pkg.sv =====
// shared constants and types for the great circle distance pipeline
// no dependencies
package gcd_pkg;

  localparam int unsigned STEPS = 30;
  localparam int unsigned XY_W  = 34;
  localparam int unsigned Z_W   = 33;

  localparam logic [30:0] ONE_Q30         = 31'd1073741824;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [30:0] PIR_Q16         = 31'd1311708728;

  // arctan(2^-i) in turn units, 2^30 is a quarter turn
  localparam logic [31:0] ATAN_TURNS [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // pipeline control handed to each sub-pipeline
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

endpackage

// ===== rtl/gcd_if.sv =====
// valid/ready stream interfaces for coordinate pairs and distances
// no dependencies
interface gcd_in_if #(
  parameter int unsigned ANGLE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] first_latitude;
  logic signed [ANGLE_BITS-1:0] first_longitude;
  logic signed [ANGLE_BITS-1:0] second_latitude;
  logic signed [ANGLE_BITS-1:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if #(
  parameter int unsigned DISTANCE_FRACTION_BITS = 8
);
  logic                                 valid;
  logic                                 ready;
  logic [15+DISTANCE_FRACTION_BITS-1:0] dist_km;

  modport source (output valid, dist_km, input ready);
  modport sink (input valid, dist_km, output ready);
endinterface

// ===== rtl/gcd_cos_pipe.sv =====
// pipelined cordic rotation, cosine of a 32-bit turn angle in q30
// depends on gcd_pkg
module gcd_cos_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcd_pkg::pipe_ctrl_t ctrl_i,
  input  logic [31:0]         turn_i,
  output logic                valid_o,
  output logic signed [31:0]  cos_o
);

  localparam int unsigned W = gcd_pkg::XY_W;
  localparam logic signed [W-1:0] ONE  = W'(signed'({1'b0, gcd_pkg::ONE_Q30}));
  localparam logic signed [W-1:0] HALF = W'(signed'(35'd2147483648));
  localparam logic signed [W-1:0] GAIN = W'(signed'({1'b0, gcd_pkg::CORDIC_GAIN_Q30}));

  logic signed [W-1:0] x_q [gcd_pkg::STEPS];
  logic signed [W-1:0] y_q [gcd_pkg::STEPS];
  logic signed [W-1:0] t_q [gcd_pkg::STEPS];
  logic                neg_q [gcd_pkg::STEPS];
  logic                vld_q [gcd_pkg::STEPS];

  // fold the angle into plus or minus a quarter turn
  logic signed [W-1:0] t_raw, t_red;
  logic                neg_red;
  assign t_raw = W'(signed'(turn_i));
  always_comb begin
    t_red   = t_raw;
    neg_red = 1'b0;
    if (t_raw > ONE) begin
      t_red   = t_raw - HALF;
      neg_red = 1'b1;
    end else if (t_raw < -ONE) begin
      t_red   = t_raw + HALF;
      neg_red = 1'b1;
    end
  end

  for (genvar k = 0; k < gcd_pkg::STEPS; k++) begin : g_step
    logic signed [W-1:0] x_in, y_in, t_in, x_d, y_d, t_d, atan_k;
    logic                neg_in, vld_in;
    if (k == 0) begin : g_first
      assign x_in   = GAIN;
      assign y_in   = '0;
      assign t_in   = t_red;
      assign neg_in = neg_red;
      assign vld_in = ctrl_i.valid;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign t_in   = t_q[k-1];
      assign neg_in = neg_q[k-1];
      assign vld_in = vld_q[k-1];
    end
    assign atan_k = W'(signed'({1'b0, gcd_pkg::ATAN_TURNS[k]}));

    // one micro-rotation
    always_comb begin
      if (t_in >= 0) begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        t_d = t_in - atan_k;
      end else begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        t_d = t_in + atan_k;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.advance) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        x_q[k]   <= x_d;
        y_q[k]   <= y_d;
        t_q[k]   <= t_d;
        neg_q[k] <= neg_in;
      end
    end
  end

  // undo the half-turn fold
  logic signed [W-1:0] x_out;
  assign x_out   = neg_q[gcd_pkg::STEPS-1] ? -x_q[gcd_pkg::STEPS-1] : x_q[gcd_pkg::STEPS-1];
  assign cos_o   = x_out[31:0];
  assign valid_o = vld_q[gcd_pkg::STEPS-1];

endmodule

// ===== rtl/gcd_sqrt_pipe.sv =====
// pipelined integer square root of a 61-bit value, one root bit per stage
// depends on gcd_pkg
module gcd_sqrt_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcd_pkg::pipe_ctrl_t ctrl_i,
  input  logic [60:0]         value_i,
  output logic                valid_o,
  output logic [30:0]         root_o
);

  localparam int unsigned NSTAGE = 31;

  logic [60:0] rem_q  [NSTAGE];
  logic [60:0] root_q [NSTAGE];
  logic        vld_q  [NSTAGE];

  for (genvar k = 0; k < NSTAGE; k++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2*k);
    logic [60:0] rem_in, root_in, rem_d, root_d;
    logic [61:0] trial;
    logic        vld_in;
    if (k == 0) begin : g_first
      assign rem_in  = value_i;
      assign root_in = '0;
      assign vld_in  = ctrl_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // trial subtract of root plus the current bit
    assign trial = {1'b0, root_in} + BIT;
    always_comb begin
      if ({1'b0, rem_in} >= trial) begin
        rem_d  = 61'({1'b0, rem_in} - trial);
        root_d = 61'({1'b0, root_in >> 1} + BIT);
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.advance) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o  = root_q[NSTAGE-1][30:0];
  assign valid_o = vld_q[NSTAGE-1];

endmodule

// ===== rtl/gcd_atan_pipe.sv =====
// pipelined cordic vectoring, atan2(y, x) in turn units (2^30 is 90 degrees)
// depends on gcd_pkg
module gcd_atan_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gcd_pkg::pipe_ctrl_t             ctrl_i,
  input  logic [30:0]                     y_i,
  input  logic [30:0]                     x_i,
  output logic                            valid_o,
  output logic signed [gcd_pkg::Z_W-1:0]  angle_o
);

  localparam int unsigned W  = gcd_pkg::XY_W;
  localparam int unsigned ZW = gcd_pkg::Z_W;

  logic signed [W-1:0]  x_q [gcd_pkg::STEPS];
  logic signed [W-1:0]  y_q [gcd_pkg::STEPS];
  logic signed [ZW-1:0] z_q [gcd_pkg::STEPS];
  logic                 vld_q [gcd_pkg::STEPS];

  for (genvar k = 0; k < gcd_pkg::STEPS; k++) begin : g_step
    logic signed [W-1:0]  x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d, atan_k;
    logic                 vld_in;
    if (k == 0) begin : g_first
      assign x_in   = W'(signed'({1'b0, x_i}));
      assign y_in   = W'(signed'({1'b0, y_i}));
      assign z_in   = '0;
      assign vld_in = ctrl_i.valid;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
      assign vld_in = vld_q[k-1];
    end
    assign atan_k = ZW'(signed'({1'b0, gcd_pkg::ATAN_TURNS[k]}));

    // drive y toward zero, accumulate the angle
    always_comb begin
      if (y_in >= 0) begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + atan_k;
      end else begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - atan_k;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.advance) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
      end
    end
  end

  assign angle_o = z_q[gcd_pkg::STEPS-1];
  assign valid_o = vld_q[gcd_pkg::STEPS-1];

endmodule

// ===== rtl/great_circle_distance.sv =====
// Haversine distance pipeline.
// Throughput: one coordinate pair per cycle; the whole pipeline holds when the
// output register is full and not taken, so input ready follows output ready.
// Depth: cordic cosine (30), square root (31) and cordic arctangent (30) in series, plus 6.
// Reset (async, active low) clears all valid bits; payload registers are not reset.
`include "great_circle_distance_defines.svh"

module great_circle_distance #(
  parameter int unsigned ANGLE_BITS             = 32,
  parameter int unsigned DISTANCE_FRACTION_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcd_in_if.sink     in_i,
  gcd_out_if.source  out_o
);

  localparam int unsigned OUT_W = 15 + DISTANCE_FRACTION_BITS;
  localparam int unsigned SHIFT = 46 - DISTANCE_FRACTION_BITS;
  localparam logic [62:0] RND   = 63'd1 << (SHIFT - 1);
  localparam logic [62:0] DIST_MAX =
    ((63'({gcd_pkg::ONE_Q30, 30'd0}) + 0) == 0) ? '0 :
    (((63'(gcd_pkg::ONE_Q30) * 63'(gcd_pkg::PIR_Q16)) + RND) >> SHIFT);

  logic advance;
  logic out_vld_q;
  logic [OUT_W-1:0] out_dist_q;

  // whole pipeline moves when the output register can take a result
  assign advance     = !out_vld_q || out_o.ready;
  assign in_i.ready  = advance;

  // angles to 32-bit turns
  logic [ANGLE_BITS-1:0] raw [4];
  logic [31:0]           turn [4];
  assign raw[0] = in_i.first_latitude;
  assign raw[1] = in_i.first_longitude;
  assign raw[2] = in_i.second_latitude;
  assign raw[3] = in_i.second_longitude;
  for (genvar i = 0; i < 4; i++) begin : g_turn
    if (ANGLE_BITS >= 32) begin : g_drop
      assign turn[i] = raw[i][ANGLE_BITS-1 -: 32];
    end else begin : g_pad
      assign turn[i] = {raw[i], {(32 - ANGLE_BITS){1'b0}}};
    end
  end

  // stage 0: latitudes and wrapped differences
  logic [31:0] lat1_q, lat2_q, dlat_q, dlon_q;
  logic        s0_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (advance) begin
      s0_vld_q <= in_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      lat1_q <= turn[0];
      lat2_q <= turn[2];
      dlat_q <= turn[2] - turn[0];
      dlon_q <= turn[3] - turn[1];
    end
  end

  // four cosines in parallel
  gcd_pkg::pipe_ctrl_t cos_ctrl;
  assign cos_ctrl = '{advance: advance, valid: s0_vld_q};
  logic              cos_vld [4];
  logic signed [31:0] cos_v  [4];
  logic [31:0]        cos_in [4];
  assign cos_in[0] = lat1_q;
  assign cos_in[1] = lat2_q;
  assign cos_in[2] = dlat_q;
  assign cos_in[3] = dlon_q;
  for (genvar i = 0; i < 4; i++) begin : g_cos
    gcd_cos_pipe u_cos (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cos_ctrl),
      .turn_i  (cos_in[i]),
      .valid_o (cos_vld[i]),
      .cos_o   (cos_v[i])
    );
  end

  // stage 1: cos product and haversines
  logic signed [63:0] cc_full;
  logic signed [33:0] hlat_full, hlon_full;
  logic signed [32:0] cc_q, hlat1_q, hlon_q;
  logic               s1_vld_q;
  assign cc_full   = cos_v[0] * cos_v[1];
  assign hlat_full = (34'sd1073741824 - 34'(cos_v[2])) >>> 1;
  assign hlon_full = (34'sd1073741824 - 34'(cos_v[3])) >>> 1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= cos_vld[0] & cos_vld[1] & cos_vld[2] & cos_vld[3];
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cc_q    <= cc_full[62:30];
      hlat1_q <= hlat_full[32:0];
      hlon_q  <= hlon_full[32:0];
    end
  end

  // stage 2: longitude term
  logic signed [65:0] term_full;
  logic signed [33:0] term_q;
  logic signed [32:0] hlat2_q;
  logic               s2_vld_q;
  assign term_full = cc_q * hlon_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      term_q  <= term_full[63:30];
      hlat2_q <= hlat1_q;
    end
  end

  // stage 3: a, clamped to [0, 1]
  logic signed [34:0] a_sum;
  logic [30:0]        a_d, a_q;
  logic               s3_vld_q;
  assign a_sum = 35'(hlat2_q) + 35'(term_q);
  always_comb begin
    if (a_sum < 0) begin
      a_d = '0;
    end else if (a_sum > 35'(signed'({1'b0, gcd_pkg::ONE_Q30}))) begin
      a_d = gcd_pkg::ONE_Q30;
    end else begin
      a_d = a_sum[30:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_q <= a_d;
    end
  end

  // square roots of a and 1 - a
  gcd_pkg::pipe_ctrl_t sq_ctrl;
  assign sq_ctrl = '{advance: advance, valid: s3_vld_q};
  logic [30:0] sa, sb, one_minus_a;
  logic        sa_vld, sb_vld;
  assign one_minus_a = gcd_pkg::ONE_Q30 - a_q;
  gcd_sqrt_pipe u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sq_ctrl),
    .value_i ({a_q, 30'd0}),
    .valid_o (sa_vld),
    .root_o  (sa)
  );
  gcd_sqrt_pipe u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sq_ctrl),
    .value_i ({one_minus_a, 30'd0}),
    .valid_o (sb_vld),
    .root_o  (sb)
  );

  // half the central angle
  gcd_pkg::pipe_ctrl_t at_ctrl;
  logic signed [gcd_pkg::Z_W-1:0] z;
  logic                           z_vld;
  assign at_ctrl = '{advance: advance, valid: sa_vld & sb_vld};
  gcd_atan_pipe u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (at_ctrl),
    .y_i     (sa),
    .x_i     (sb),
    .valid_o (z_vld),
    .angle_o (z)
  );

  // stage 4: clamp and scale by radius times pi
  logic [30:0] zc;
  logic [61:0] dist_prod_q;
  logic        s4_vld_q;
  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > gcd_pkg::Z_W'(signed'({1'b0, gcd_pkg::ONE_Q30}))) begin
      zc = gcd_pkg::ONE_Q30;
    end else begin
      zc = z[30:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (advance) begin
      s4_vld_q <= z_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      dist_prod_q <= 62'(zc) * 62'(gcd_pkg::PIR_Q16);
    end
  end

  // output register: round half up and keep DISTANCE_FRACTION_BITS fraction bits
  logic [62:0] dist_sum;
  assign dist_sum = {1'b0, dist_prod_q} + RND;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= s4_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_dist_q <= dist_sum[SHIFT +: OUT_W];
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.dist_km = out_dist_q;

  // checks
  `GCD_ASSERT_NOW(a_in_range, clk_i, rst_ni, s3_vld_q, a_q <= gcd_pkg::ONE_Q30)
  `GCD_ASSERT_NOW(dist_in_range, clk_i, rst_ni, out_vld_q, 63'(out_dist_q) <= DIST_MAX)
  `GCD_ASSERT_NOW(ready_when_empty, clk_i, rst_ni, !out_vld_q, in_i.ready)
  `GCD_ASSERT_NEXT(stall_holds_result, clk_i, rst_ni, out_vld_q && !out_o.ready,
                   out_vld_q && $stable(out_dist_q))

endmodule

// ===== test/gcd_checker.sv =====
// distance checker: watches both streams, predicts each haversine distance, compares
// depends on gcd_pkg and the gcd_in_if / gcd_out_if stream interfaces
module gcd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gcd_in_if    in_i,
  gcd_out_if   out_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QUARTER = 64'sd1 << 30;

  logic [22:0] distance_q[$];

  // cosine of a 32-bit turn angle, Q30, by rotation
  function automatic longint cos_q30(logic [31:0] turn);
    longint t, x, y, dx, dy;
    bit     flip;
    t = longint'({32'b0, turn});
    x = longint'({32'b0, gcd_pkg::CORDIC_GAIN_Q30});
    y = 0;
    flip = 1'b0;
    if (t >= (64'sd1 << 31)) t -= (64'sd1 << 32);
    // fold into the right half plane
    if (t > QUARTER) begin
      t -= (64'sd1 << 31);
      flip = 1'b1;
    end else if (t < -QUARTER) begin
      t += (64'sd1 << 31);
      flip = 1'b1;
    end
    for (int i = 0; i < gcd_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x -= dx; y += dy; t -= longint'({32'b0, gcd_pkg::ATAN_TURNS[i]});
      end else begin
        x += dx; y -= dy; t += longint'({32'b0, gcd_pkg::ATAN_TURNS[i]});
      end
    end
    return flip ? -x : x;
  endfunction

  // arctangent of y/x for non-negative operands, 2^30 is a quarter turn
  function automatic longint atan_q30(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < gcd_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'({32'b0, gcd_pkg::ATAN_TURNS[i]});
      end else begin
        x -= dx; y += dy; z -= longint'({32'b0, gcd_pkg::ATAN_TURNS[i]});
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint hav_q30(logic [31:0] turn);
    return (QUARTER - cos_q30(turn)) >>> 1;
  endfunction

  function automatic logic [22:0] predict_distance(logic [31:0] lat_a, logic [31:0] lon_a,
                                                   logic [31:0] lat_b, logic [31:0] lon_b);
    longint hlat, hlon, cc, a, sa, sb, z;
    longint unsigned d;
    hlat = hav_q30(lat_b - lat_a);
    hlon = hav_q30(lon_b - lon_a);
    cc = (cos_q30(lat_a) * cos_q30(lat_b)) >>> 30;
    a = hlat + ((cc * hlon) >>> 30);
    if (a < 0) a = 0;
    if (a > QUARTER) a = QUARTER;
    sa = longint'(root_floor(longint'(a) << 30));
    sb = longint'(root_floor(longint'(QUARTER - a) << 30));
    z = atan_q30(sa, sb);
    if (z < 0) z = 0;
    if (z > QUARTER) z = QUARTER;
    d = (longint'(z) * longint'({33'b0, gcd_pkg::PIR_Q16}) + (64'd1 << 37)) >> 38;
    return d[22:0];
  endfunction

  assign pending_o = distance_q.size();

  // predict on each input transfer, compare on each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    logic [22:0] want;
    if (!rst_ni) begin
      errors_o  <= 0;
      checked_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready)
        distance_q.insert(distance_q.size(),
                          predict_distance(in_i.first_latitude, in_i.first_longitude,
                                           in_i.second_latitude, in_i.second_longitude));
      if (out_i.valid && out_i.ready) begin
        if (distance_q.size() == 0) begin
          $error("dist_km: no result expected, got %0d", out_i.dist_km);
          errors_o <= errors_o + 1;
        end else begin
          want = distance_q.pop_front();
          checked_o <= checked_o + 1;
          if (out_i.dist_km !== want) begin
            $error("dist_km: expected %0d, got %0d", want, out_i.dist_km);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_great_circle_distance.sv =====
// top of the great circle distance testbench: clock, reset, coordinate stimulus, verdict
// depends on gcd_pkg, the stream interfaces, the block and gcd_checker
module tb_great_circle_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_PAIRS = 480;
  localparam longint CYCLE_LIMIT  = 400000;
  localparam logic [31:0] NORTH = 32'h4000_0000;
  localparam logic [31:0] SOUTH = 32'hC000_0000;
  localparam logic [31:0] DATELINE = 32'h8000_0000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  int     errors, pending, checked;
  int     sent = 0;
  int     received = 0;
  longint cycles = 0;

  gcd_in_if  in_if ();
  gcd_out_if out_if ();

  great_circle_distance i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gcd_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_i     (out_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.first_latitude <= '0;
    in_if.first_longitude <= '0;
    in_if.second_latitude <= '0;
    in_if.second_longitude <= '0;
    out_if.ready <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [31:0] any_latitude();
    return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
  endfunction

  // offer one coordinate pair, keep valid high for a back-to-back follower
  task automatic send_pair(logic [31:0] lat_a, logic [31:0] lon_a,
                           logic [31:0] lat_b, logic [31:0] lon_b, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.first_latitude <= lat_a;
    in_if.first_longitude <= lon_a;
    in_if.second_latitude <= lat_b;
    in_if.second_longitude <= lon_b;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(18, 0);
  endfunction

  // result side: random stalls, one long hold-off after 150 results
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && received == 150) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(18, 0);
      if ((received / 40) % 3 == 1) stall = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      received++;
    end
  end

  // coordinate stimulus
  initial begin
    logic [31:0] la, lo, lb, lp;
    bit          burst;
    @(posedge rst_ni);
    @(posedge clk_i);
    // same point, antipodes, poles, dateline, extreme longitudes
    send_pair(0, 0, 0, 0, 0);
    send_pair(0, 0, 0, DATELINE, 1);
    send_pair(NORTH, 0, SOUTH, 0, 0);
    send_pair(NORTH, 32'h1234_5678, NORTH, 32'h8765_4321, 0);
    send_pair(SOUTH, 32'h7FFF_FFFF, SOUTH, DATELINE, 2);
    send_pair(0, 32'h7FFF_FFFF, 0, DATELINE, 0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 0);
    send_pair(NORTH, DATELINE, SOUTH, 32'h7FFF_FFFF, 3);
    send_pair(32'h2000_0000, 32'h4000_0000, 32'hE000_0000, 32'hC000_0000, 0);
    send_pair(32'h3FFF_FFFF, 0, 32'hC000_0001, DATELINE, 0);
    send_pair(0, 0, 0, 32'h4000_0000, 0);
    send_pair(0, 0, 32'h0000_0001, 0, 0);
    send_pair(32'h1555_5555, 32'h0AAA_AAAA, 32'h1555_5556, 32'h0AAA_AAAB, 0);
    send_pair(SOUTH, 0, NORTH, DATELINE, 4);
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      burst = ((n / 30) % 4 == 2);
      // once, drain the pipe completely before going on
      if (n == 250) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      la = any_latitude();
      lo = $urandom();
      case ($urandom_range(3, 0))
        0: begin lb = la + $urandom_range(32'h0000_FFFF, 0); lp = lo + $urandom_range(255, 0); end
        1: begin lb = -la; lp = lo ^ DATELINE; end
        default: begin lb = any_latitude(); lp = $urandom(); end
      endcase
      if (lb > NORTH && lb < SOUTH) lb = any_latitude();
      send_pair(la, lo, lb, lp, draw_gap(burst));
    end
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("sent %0d coordinate pairs, checked %0d distances incl. poles, antipodes,",
             sent, checked);
    $display("near-identical points, one long output hold-off and one full drain");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
